### rtl/lprx_pkg.sv
// Package for the length-prefixed packet receiver.
// Holds the transfer structs, opcode and status codes. No dependencies.
`default_nettype none

package lprx_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RECV = 2'b10
  } rx_state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [7:0] byte_index;
    logic       is_data;
    logic       last;
    logic [1:0] status;
    logic [7:0] bytes_received;
  } out_item_t;

  localparam logic [7:0] TickSat = 8'hFF;

endpackage

`default_nettype wire

### rtl/lprx_in_reg.sv
// Input register stage of the packet receiver.
// Depends on lprx_pkg for the input transfer struct.
`default_nettype none

module lprx_in_reg import lprx_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  input  wire logic     advance_i,
  output logic          item_valid_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_stall_o   = valid_q && !advance_i;
  assign valid_d      = in_stall_o ? valid_q : in_valid_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/lprx_core.sv
// Packet state and per-item update of the packet receiver.
// Holds the timeout register. Depends on lprx_pkg.
`default_nettype none

module lprx_core import lprx_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic     fire_i,
  input  wire in_item_t item_i,
  output logic          res_valid_o,
  output out_item_t     res_o
);

  localparam logic [7:0] MaxLenB = 8'(MAX_LEN);

  rx_state_e  state_q, state_d;
  logic [7:0] count_q, count_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] ticks_q, ticks_d;
  logic [7:0] timeout_q;
  logic [7:0] cnt_inc, sum_new, len_new, tick_inc;

  assign cnt_inc  = count_q + 8'd1;
  assign sum_new  = sum_q + item_i.rx_byte;
  assign len_new  = (count_q == 8'd0) ? item_i.rx_byte : len_q;
  assign tick_inc = (ticks_q == TickSat) ? TickSat : ticks_q + 8'd1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    len_d       = len_q;
    sum_d       = sum_q;
    ticks_d     = ticks_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire_i) begin
      unique case (opcode_e'(item_i.opcode))
        OP_START: begin
          state_d = S_RECV;
          count_d = '0;
          len_d   = '0;
          sum_d   = '0;
          ticks_d = '0;
        end
        OP_BYTE: begin
          if (state_q == S_RECV) begin
            res_valid_o = 1'b1;
            if (count_q >= MaxLenB) begin
              state_d      = S_IDLE;
              res_o.last   = 1'b1;
              res_o.status = ST_OVERFLOW;
            end else begin
              count_d          = cnt_inc;
              sum_d            = sum_new;
              len_d            = len_new;
              ticks_d          = '0;
              res_o.byte_out   = item_i.rx_byte;
              res_o.byte_index = count_q;
              res_o.is_data    = 1'b1;
              if (cnt_inc >= len_new) begin
                state_d              = S_IDLE;
                res_o.last           = 1'b1;
                res_o.status         = (sum_new == 8'd0) ? ST_OK : ST_CHECKSUM;
                res_o.bytes_received = cnt_inc;
              end
            end
          end
        end
        OP_TICK: begin
          if (state_q == S_RECV && timeout_q != 8'd0) begin
            ticks_d = tick_inc;
            if (tick_inc >= timeout_q) begin
              state_d              = S_IDLE;
              res_valid_o          = 1'b1;
              res_o.last           = 1'b1;
              res_o.status         = ST_TIMEOUT;
              res_o.bytes_received = count_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      len_q     <= '0;
      sum_q     <= '0;
      ticks_q   <= '0;
      timeout_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      ticks_q <= ticks_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("receiver state not one-hot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxLenB) else $error("byte count beyond MAX_LEN");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> state_q == S_IDLE)
    else $error("packet end did not return to idle");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && item_i.opcode != OP_START |-> !res_valid_o)
    else $error("result produced while idle");

endmodule

`default_nettype wire

### rtl/lprx_out_reg.sv
// Result register of the packet receiver.
// Depends on lprx_pkg for the output transfer struct.
`default_nettype none

module lprx_out_reg import lprx_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire logic      res_valid_i,
  input  wire out_item_t res_i,
  output logic           advance_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign advance_o   = !valid_q || !out_stall_i;
  assign valid_d     = advance_o ? (fire_i && res_valid_i) : valid_q;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && fire_i && res_valid_i) begin
      item_q <= res_i;
    end
  end

endmodule

`default_nettype wire

### rtl/length_prefixed_packet_receiver_unit.sv
// Each item is held in the input register, and its result in the result register, before it is presented.
// Throughput: one item per cycle while out_stall_i is low, set by the input and result registers.
// in_stall_o rises only while a held result is stalled at the output.
// Reset: idle, counters, checksum and timeout register cleared (timeout off).
// Top level of the packet receiver; depends on lprx_pkg, lprx_in_reg,
// lprx_core and lprx_out_reg.
`default_nettype none

module length_prefixed_packet_receiver_unit import lprx_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_item_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  logic      advance, item_valid, fire, res_valid;
  in_item_t  item;
  out_item_t res;

  assign cfg_ready_o = 1'b1;
  assign fire        = item_valid && advance;

  lprx_in_reg u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  lprx_core #(.MAX_LEN(MAX_LEN)) u_core (
    .clk_i,
    .rst_ni,
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i,
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lprx_out_reg u_out (
    .clk_i,
    .rst_ni,
    .fire_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

endmodule

`default_nettype wire

### bench/length_prefixed_packet_receiver_unit_tb.sv
// Self-checking testbench for length_prefixed_packet_receiver_unit.
// Predicts each result from a behavioural model of the receiver; needs only lprx_pkg
// and the RTL.
`default_nettype none

module length_prefixed_packet_receiver_unit_tb;
  import lprx_pkg::*;

  localparam int         MaxLen     = 64;
  localparam int         QuietLimit = 2000;
  localparam logic [1:0] OpUnused   = 2'd3;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = '0;

  length_prefixed_packet_receiver_unit #(.MAX_LEN(MaxLen)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // receiver state as predicted
  bit         rx_active = 1'b0;
  logic [7:0] rx_count  = '0;
  logic [7:0] rx_len    = '0;
  logic [7:0] rx_sum    = '0;
  logic [7:0] rx_idle   = '0;
  logic [7:0] tmo_ticks = '0;

  out_item_t  pending_results[$];
  out_item_t  want;
  bit         idle_on = 1'b1;
  int         errors, item_count, results_seen, quiet_cycles, n_settings;
  int         n_ok, n_sum_err, n_timeout, n_overflow;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit predict_rx(input in_item_t it, output out_item_t res);
    res = '0;
    case (it.opcode)
      OP_START: begin
        rx_active = 1'b1;
        rx_count  = '0;
        rx_len    = '0;
        rx_sum    = '0;
        rx_idle   = '0;
      end
      OP_BYTE: if (rx_active) begin
        res.last = 1'b1;
        if (rx_count >= MaxLen) begin
          rx_active  = 1'b0;
          res.status = ST_OVERFLOW;
          return 1'b1;
        end
        res.byte_index = rx_count;
        res.byte_out   = it.rx_byte;
        res.is_data    = 1'b1;
        rx_count       = rx_count + 8'd1;
        rx_sum         = rx_sum + it.rx_byte;
        rx_idle        = '0;
        if (rx_count == 8'd1) rx_len = it.rx_byte;
        if (rx_count >= rx_len) begin
          rx_active          = 1'b0;
          res.status         = (rx_sum == 8'd0) ? ST_OK : ST_CHECKSUM;
          res.bytes_received = rx_count;
        end else begin
          res.last = 1'b0;
        end
        return 1'b1;
      end
      OP_TICK: if (rx_active && tmo_ticks != 8'd0) begin
        if (rx_idle < TickSat) rx_idle = rx_idle + 8'd1;
        if (rx_idle >= tmo_ticks) begin
          rx_active          = 1'b0;
          res.last           = 1'b1;
          res.status         = ST_TIMEOUT;
          res.bytes_received = rx_count;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] checksum_byte();
    return 8'h00 - rx_sum;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] data);
    in_item_t  it;
    out_item_t res;
    it.opcode  = op;
    it.rx_byte = data;
    while (idle_on && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item_count++;
    if (predict_rx(it, res)) pending_results.push_back(res);
  endtask

  // drain the pipeline, then write the timeout register
  task automatic write_timeout(input logic [7:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tmo_ticks = value;
    n_settings++;
  endtask

  task automatic send_packet(input logic [7:0] plen, input bit good);
    send_item(OP_START, 8'($urandom));
    send_item(OP_BYTE, plen);
    while (rx_active) begin
      if ($urandom_range(99) < 25)
        repeat ($urandom_range(1, 4)) if (rx_active) send_item(OP_TICK, 8'($urandom));
      if ($urandom_range(99) < 3) send_item(OpUnused, 8'($urandom));
      if ($urandom_range(199) < 3) begin
        send_item(OP_START, 8'($urandom));
        send_item(OP_BYTE, 8'($urandom_range(2, 12)));
      end
      if (rx_active)
        send_item(OP_BYTE, (good && rx_count + 8'd1 == rx_len) ? checksum_byte()
                                                             : 8'($urandom));
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 5)) send_item(2'($urandom_range(3)), 8'($urandom));
  endtask

  task automatic test_ignored_items();
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OpUnused, 8'hA5);
  endtask

  task automatic test_good_packet();
    send_item(OP_START, 8'hFF);
    send_item(OP_BYTE, 8'd6);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OpUnused, 8'h5A);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_BYTE, checksum_byte());
  endtask

  task automatic test_short_lengths();
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'd0);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'd1);
  endtask

  task automatic test_bad_checksum();
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'd3);
    send_item(OP_BYTE, 8'h42);
    send_item(OP_BYTE, checksum_byte() + 8'd1);
  endtask

  task automatic test_restart();
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'd5);
    send_item(OP_BYTE, 8'h11);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'd3);
    send_item(OP_BYTE, 8'hAA);
    send_item(OP_BYTE, checksum_byte());
  endtask

  task automatic test_timeout();
    write_timeout(8'd2);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'd9);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_START, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
  endtask

  task automatic test_max_length_and_overflow();
    write_timeout(8'd0);
    send_packet(8'(MaxLen), 1'b1);
    send_packet(8'($urandom_range(MaxLen + 1, 255)), 1'b0);
  endtask

  task automatic test_timeout_extremes();
    write_timeout(8'd1);
    send_item(OP_START, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'd4);
    send_item(OP_BYTE, 8'h33);
    send_item(OP_TICK, 8'h00);
    write_timeout(8'hFF);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'd20);
    repeat (254) send_item(OP_TICK, 8'($urandom));
    send_item(OP_BYTE, 8'h01);
    repeat (256) send_item(OP_TICK, 8'($urandom));
  endtask

  task automatic test_random_traffic(input logic [7:0] tmo, input int target);
    int         stop_at;
    int         pick;
    logic [7:0] plen;
    write_timeout(tmo);
    stop_at = item_count + target;
    while (item_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_noise();
      end else begin
        if (pick < 80)      plen = 8'($urandom_range(2, 12));
        else if (pick < 90) plen = 8'($urandom_range(13, MaxLen));
        else if (pick < 96) plen = 8'($urandom_range(0, 1));
        else                plen = 8'($urandom_range(0, 255));
        send_packet(plen, $urandom_range(99) < 85);
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 19);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result %p", out_item_o));
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.byte_out !== want.byte_out || out_item_o.byte_index !== want.byte_index
            || out_item_o.is_data !== want.is_data || out_item_o.last !== want.last
            || out_item_o.status !== want.status
            || out_item_o.bytes_received !== want.bytes_received)
          note_error($sformatf("expected %p got %p", want, out_item_o));
        if (want.last) begin
          case (want.status)
            ST_OK:       n_ok++;
            ST_TIMEOUT:  n_timeout++;
            ST_OVERFLOW: n_overflow++;
            default:     n_sum_err++;
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no transfer for %0d cycles", QuietLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int waited;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_items();
    test_good_packet();
    test_short_lengths();
    test_bad_checksum();
    test_restart();
    test_timeout();
    test_max_length_and_overflow();
    idle_on = 1'b0;
    test_timeout_extremes();
    idle_on = 1'b1;
    test_random_traffic(8'd0, 40);
    test_random_traffic(8'd1, 30);
    test_random_traffic(8'($urandom_range(2, 8)), 40);
    test_random_traffic(8'($urandom_range(3, 30)), 40);
    test_random_traffic(8'($urandom_range(2, 6)), 30);

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (6) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));

    $display("Run covered %0d items and %0d results over %0d timeout settings.",
             item_count, results_seen, n_settings);
    $display("Packets: %0d good, %0d checksum errors, %0d timeouts, %0d overflows; %0d errors.",
             n_ok, n_sum_err, n_timeout, n_overflow, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
